@@ sv/ir_key_repeat_release_filter_top_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef IR_KEY_REPEAT_RELEASE_FILTER_TOP_ASSERT_SVH
`define IR_KEY_REPEAT_RELEASE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IRKRF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("irkrf assertion failed");

// Next-cycle implication, disabled during reset.
`define IRKRF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("irkrf assertion failed");

`endif

@@ sv/irkrf_pkg.sv @@
package irkrf_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_ADDR_W    = 2;
    localparam int SIL_W         = 9;
    localparam int Q_DEPTH       = 4;

    localparam logic [7:0]       MAGIC_PROTOCOL = 8'hFF;
    localparam logic [SIL_W-1:0] SILENCE_MAX    = 9'd511;

    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST = 16'd300;
    localparam logic [CFG_W-1:0] REPEAT_GAP_RST   = 16'd100;

    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_DELAY = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_GAP   = 2'd1;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_REPEAT  = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  protocol;
        logic [15:0] address;
        logic [15:0] command;
        logic [7:0]  repeat_count;
        logic [7:0]  release_timeout_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  key_protocol;
        logic [15:0] key_address;
        logic [15:0] key_command;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [15:0] address;
        logic [15:0] command;
    } key_t;

    // events that the front hands to the queue together
    typedef struct packed {
        logic [1:0] n;
        out_item_t  ev0;
        out_item_t  ev1;
    } push_t;

    function automatic out_item_t make_event(logic [1:0] kind, key_t key, logic last);
        out_item_t e;
        e.event_kind   = kind;
        e.key_protocol = key.protocol;
        e.key_address  = key.address;
        e.key_command  = key.command;
        e.last_of_run  = last;
        return e;
    endfunction

endpackage

@@ sv/ir_key_repeat_release_filter_top.sv @@
// IR key repeat/release filter. Takes decoded key reports and 1 ms ticks on the
// s_ channel and sends press, repeat and release events on the m_ channel; a new
// press after a repeating key gives a release then a press, flagged by
// last_of_run on the second. An item is taken every cycle while the four-entry
// event queue has two free slots, so the front runs at one item per cycle and
// the output register drains one event per cycle while m_ready is high; a report
// that makes two events queues both together. Magic reports and early repeats
// give no event. repeat_delay_ms is cfg register 0, repeat_gap_ms cfg register 1.
module ir_key_repeat_release_filter_top #(
    parameter int TIME_BITS = irkrf_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [irkrf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [irkrf_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  irkrf_pkg::in_item_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output irkrf_pkg::out_item_t             m_data
);
    import irkrf_pkg::*;

    push_t     push;
    logic      q_room, q_empty, pop;
    out_item_t q_head;

    irkrf_front #(.TIME_BITS(TIME_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_room    (q_room),
        .push      (push)
    );

    irkrf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .empty   (q_empty),
        .room    (q_room),
        .head    (q_head)
    );

    irkrf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ sv/irkrf_front.sv @@
module irkrf_front #(
    parameter int TIME_BITS = irkrf_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [irkrf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [irkrf_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  irkrf_pkg::in_item_t              s_data,
    input  logic                             q_room,
    output irkrf_pkg::push_t                 push
);
    import irkrf_pkg::*;

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [CFG_W-1:0]     delay_reg, gap_reg;
    logic [TIME_BITS-1:0] since_first_reg, since_first_next;
    logic [TIME_BITS-1:0] since_sent_reg, since_sent_next;
    logic [SIL_W-1:0]     silence_reg, silence_next;
    logic [7:0]           tout_reg, tout_next;
    logic                 armed_reg, armed_next;
    logic                 repeating_reg, repeating_next;
    logic                 pending_reg, pending_next;
    key_t                 held_reg, held_next;

    logic       accept;
    key_t       key;
    logic [SIL_W-1:0] sil_inc;
    logic       too_early;

    assign s_ready = q_room;
    assign accept  = s_valid && s_ready;

    always_comb begin
        key.protocol = s_data.protocol;
        key.address  = s_data.address;
        key.command  = s_data.command;
        sil_inc      = (silence_reg == SILENCE_MAX) ? silence_reg : silence_reg + 9'd1;
        too_early    = (CMP_W'(since_first_reg) < CMP_W'(delay_reg))
                    || (CMP_W'(since_sent_reg) < CMP_W'(gap_reg));

        since_first_next = since_first_reg;
        since_sent_next  = since_sent_reg;
        silence_next     = silence_reg;
        tout_next        = tout_reg;
        armed_next       = armed_reg;
        repeating_next   = repeating_reg;
        pending_next     = pending_reg;
        held_next        = held_reg;
        push             = '0;

        if (accept) begin
            if (s_data.req_type == REQ_TICK) begin
                since_first_next = (since_first_reg == TIME_MAX) ? since_first_reg
                                                                 : since_first_reg + 1'b1;
                since_sent_next  = (since_sent_reg == TIME_MAX) ? since_sent_reg
                                                                : since_sent_reg + 1'b1;
                silence_next     = sil_inc;
                if (armed_reg && (sil_inc >= {1'b0, tout_reg})) begin
                    if (pending_reg && repeating_reg) begin
                        push.n   = 2'd1;
                        push.ev0 = make_event(EV_RELEASE, held_reg, 1'b1);
                    end
                    pending_next   = 1'b0;
                    repeating_next = 1'b0;
                    held_next      = '0;
                    armed_next     = 1'b0;
                end
            end else if (s_data.protocol != MAGIC_PROTOCOL) begin
                tout_next    = s_data.release_timeout_ms;
                armed_next   = 1'b1;
                silence_next = '0;
                if (s_data.repeat_count == 8'd0) begin
                    held_next        = key;
                    repeating_next   = 1'b0;
                    since_first_next = '0;
                    since_sent_next  = '0;
                    pending_next     = 1'b1;
                    if (repeating_reg) begin
                        // release of the old key goes ahead of the new press
                        push.n   = 2'd2;
                        push.ev0 = make_event(EV_RELEASE, held_reg, 1'b0);
                        push.ev1 = make_event(EV_PRESS, key, 1'b1);
                    end else begin
                        push.n   = 2'd1;
                        push.ev0 = make_event(EV_PRESS, key, 1'b1);
                    end
                end else if (!too_early) begin
                    repeating_next  = 1'b1;
                    since_sent_next = '0;
                    pending_next    = 1'b1;
                    push.n          = 2'd1;
                    push.ev0        = make_event(EV_REPEAT, key, 1'b1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg       <= REPEAT_DELAY_RST;
            gap_reg         <= REPEAT_GAP_RST;
            since_first_reg <= '0;
            since_sent_reg  <= TIME_MAX;
            silence_reg     <= '0;
            tout_reg        <= '0;
            armed_reg       <= 1'b0;
            repeating_reg   <= 1'b0;
            pending_reg     <= 1'b0;
            held_reg        <= '0;
        end else begin
            since_first_reg <= since_first_next;
            since_sent_reg  <= since_sent_next;
            silence_reg     <= silence_next;
            tout_reg        <= tout_next;
            armed_reg       <= armed_next;
            repeating_reg   <= repeating_next;
            pending_reg     <= pending_next;
            held_reg        <= held_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_REPEAT_DELAY: delay_reg <= cfg_wdata;
                    CFG_REPEAT_GAP:   gap_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ sv/irkrf_queue.sv @@
module irkrf_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  irkrf_pkg::push_t     push,
    input  logic                 pop,
    output logic                 empty,
    output logic                 room,
    output irkrf_pkg::out_item_t head
);
    import irkrf_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam logic [PTR_W:0] ROOM_MAX = (PTR_W + 1)'(Q_DEPTH - 2);

    out_item_t        mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign empty     = (count_reg == '0);
    assign room      = (count_reg <= ROOM_MAX);
    assign head      = mem[rd_ptr_reg];
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W + 1)'(push.n) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wr_ptr_reg] <= push.ev0;
        end
        if (push.n == 2'd2) begin
            mem[wr_ptr_p1] <= push.ev1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/irkrf_back.sv @@
module irkrf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  irkrf_pkg::out_item_t q_head,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output irkrf_pkg::out_item_t m_data
);
    import irkrf_pkg::*;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;

    // refill the output register from a non-empty queue whenever it is empty or being taken
    assign pop          = !q_empty && (!m_valid_reg || m_ready);
    assign m_valid_next = pop ? 1'b1 : (m_valid_reg && !m_ready);
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= q_head;
        end
    end

endmodule

@@ sv/irkrf_checker.sv @@
`include "ir_key_repeat_release_filter_top_assert.svh"

module irkrf_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input irkrf_pkg::out_item_t m_data
);
    import irkrf_pkg::*;

    // stalled result holds
    `IRKRF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    `IRKRF_ASSERT_NOW(a_kind_legal, aclk, aresetn, m_valid, m_data.event_kind == EV_PRESS || m_data.event_kind == EV_REPEAT || m_data.event_kind == EV_RELEASE)

    // only a release can be followed by another event of the same item
    `IRKRF_ASSERT_NOW(a_last_flag, aclk, aresetn, m_valid && m_data.event_kind != EV_RELEASE, m_data.last_of_run)

    `IRKRF_ASSERT_NOW(a_reset_idle, aclk, aresetn, $past(!aresetn), !m_valid)

endmodule

bind ir_key_repeat_release_filter_top irkrf_checker u_irkrf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
